[rtl/assert_macros.svh]
// Assertion macros shared by the sequence engine RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while reset is asserted.
`define ESP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that is also evaluated during reset.
`define ESP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/esp_ars_pkg.sv]
// Types, codes and constants of the ESP anti-replay sequence engine.
package esp_ars_pkg;

    // Width of the replay window in bits and of an index into it.
    localparam int WINDOW_BITS = 64;
    localparam int WIN_IDX_W   = $clog2(WINDOW_BITS);

    // Reset values of the configuration registers.
    localparam logic [15:0] MAX_ADVANCE_RESET     = 16'd16384;
    localparam logic [31:0] REKEY_THRESHOLD_RESET = 32'd1000000000;

    // Register indexes of the configuration port.
    localparam logic REG_MAX_ADVANCE     = 1'b0;
    localparam logic REG_REKEY_THRESHOLD = 1'b1;

    // Stream payload widths.
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 72;

    typedef logic [WINDOW_BITS-1:0] window_t;

    // Item functions.
    typedef enum logic [2:0] {
        FN_RECV       = 3'd0,
        FN_SEND       = 3'd1,
        FN_RESYNC     = 3'd2,
        FN_RESET_RECV = 3'd3,
        FN_RESET_SEND = 3'd4
    } func_t;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_ACCEPT  = 3'd0,
        ST_CONTROL = 3'd1,
        ST_RANGE   = 3'd2,
        ST_REPLAY  = 3'd3,
        ST_AUTH    = 3'd4,
        ST_DONE    = 3'd5
    } status_t;

    // Configuration register values.
    typedef struct packed {
        logic [15:0] max_advance;
        logic [31:0] rekey_threshold;
    } cfg_t;

    // One input item.
    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] seq_number;
        logic        auth_ok;
        logic        control_frame;
        logic [31:0] peer_receive_seq;
        logic [31:0] peer_send_seq;
    } item_t;

    // One result item.
    typedef struct packed {
        status_t     status;
        logic [31:0] send_seq;
        logic        rekey_warning;
        logic [31:0] window_top;
    } result_t;

endpackage

[rtl/esp_ars_apb_regs.sv]
// APB configuration registers of the sequence engine.
module esp_ars_apb_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output esp_ars_pkg::cfg_t  cfg
);

    logic [15:0] max_advance_reg;
    logic [31:0] rekey_threshold_reg;
    logic        wr_en;
    logic        reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes in the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_advance_reg     <= esp_ars_pkg::MAX_ADVANCE_RESET;
            rekey_threshold_reg <= esp_ars_pkg::REKEY_THRESHOLD_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                esp_ars_pkg::REG_MAX_ADVANCE:     max_advance_reg     <= pwdata[15:0];
                esp_ars_pkg::REG_REKEY_THRESHOLD: rekey_threshold_reg <= pwdata;
                default:                          max_advance_reg     <= max_advance_reg;
            endcase
        end
    end

    // Read data.
    always_comb
    begin
        case (reg_sel)
            esp_ars_pkg::REG_MAX_ADVANCE:     prdata = {16'd0, max_advance_reg};
            esp_ars_pkg::REG_REKEY_THRESHOLD: prdata = rekey_threshold_reg;
            default:                          prdata = 32'd0;
        endcase
    end

    assign cfg.max_advance     = max_advance_reg;
    assign cfg.rekey_threshold = rekey_threshold_reg;

endmodule

[rtl/esp_ars_engine.sv]
// Sequence state and the combinational receive, send and resync logic.
`include "assert_macros.svh"

module esp_ars_engine (
    input  logic                  clk,
    input  logic                  rst_n,
    input  esp_ars_pkg::cfg_t     cfg,
    input  logic                  step,
    input  esp_ars_pkg::item_t    item,
    output esp_ars_pkg::result_t  res
);

    localparam logic [31:0] WIN_LIMIT = 32'(esp_ars_pkg::WINDOW_BITS);
    localparam esp_ars_pkg::window_t WIN_ONES = {esp_ars_pkg::WINDOW_BITS{1'b1}};
    localparam esp_ars_pkg::window_t WIN_ONE  = esp_ars_pkg::window_t'(1);

    logic [31:0]           top_reg, top_next;
    esp_ars_pkg::window_t  window_reg, window_next;
    logic [31:0]           send_reg, send_next;

    logic [31:0]           dist_fwd;
    logic [31:0]           dist_back;
    logic                  backward;
    logic [esp_ars_pkg::WIN_IDX_W-1:0] back_idx;
    esp_ars_pkg::window_t  win_shifted;
    logic [31:0]           send_inc;

    // Distances between the received number and the window top.
    assign dist_fwd    = item.seq_number - top_reg;
    assign dist_back   = top_reg - item.seq_number;
    assign backward    = (dist_fwd == 32'd0) || dist_fwd[31];
    assign back_idx    = dist_back[esp_ars_pkg::WIN_IDX_W-1:0];
    assign win_shifted = (dist_fwd >= WIN_LIMIT) ? '0
                       : (window_reg << dist_fwd[esp_ars_pkg::WIN_IDX_W-1:0]);

    // Next send number, skipping zero on wrap.
    assign send_inc = (send_reg == 32'hFFFF_FFFF) ? 32'd1 : (send_reg + 32'd1);

    // Item decode and state update.
    always_comb
    begin
        top_next          = top_reg;
        window_next       = window_reg;
        send_next         = send_reg;
        res.status        = esp_ars_pkg::ST_DONE;
        res.send_seq      = 32'd0;
        res.rekey_warning = 1'b0;
        case (item.func)
            esp_ars_pkg::FN_RECV:
            begin
                if (item.seq_number == 32'd0)
                begin
                    res.status = item.auth_ok ? esp_ars_pkg::ST_CONTROL : esp_ars_pkg::ST_AUTH;
                end
                else if (backward)
                begin
                    if (dist_back >= WIN_LIMIT)
                        res.status = esp_ars_pkg::ST_RANGE;
                    else if (window_reg[back_idx])
                        res.status = esp_ars_pkg::ST_REPLAY;
                    else if (!item.auth_ok)
                        res.status = esp_ars_pkg::ST_AUTH;
                    else
                    begin
                        window_next = window_reg | (WIN_ONE << back_idx);
                        res.status  = esp_ars_pkg::ST_ACCEPT;
                    end
                end
                else if (dist_fwd > {16'd0, cfg.max_advance})
                begin
                    res.status = esp_ars_pkg::ST_RANGE;
                end
                else if (!item.auth_ok)
                begin
                    res.status = esp_ars_pkg::ST_AUTH;
                end
                else
                begin
                    window_next = win_shifted | WIN_ONE;
                    top_next    = item.seq_number;
                    res.status  = esp_ars_pkg::ST_ACCEPT;
                end
            end
            esp_ars_pkg::FN_SEND:
            begin
                if (!item.control_frame)
                begin
                    send_next         = send_inc;
                    res.send_seq      = send_inc;
                    res.rekey_warning = send_inc > cfg.rekey_threshold;
                end
            end
            esp_ars_pkg::FN_RESYNC:
            begin
                send_next   = item.peer_receive_seq + 32'd1;
                window_next = WIN_ONES;
                top_next    = item.peer_send_seq;
            end
            esp_ars_pkg::FN_RESET_RECV:
            begin
                top_next    = 32'd0;
                window_next = WIN_ONES;
            end
            esp_ars_pkg::FN_RESET_SEND:
            begin
                send_next = 32'd0;
            end
            default:
            begin
                res.status = esp_ars_pkg::ST_DONE;
            end
        endcase
        res.window_top = top_next;
    end

    // State registers, updated once per processed item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg    <= 32'd0;
            window_reg <= WIN_ONES;
            send_reg   <= 32'd0;
        end
        else if (step)
        begin
            top_reg    <= top_next;
            window_reg <= window_next;
            send_reg   <= send_next;
        end
    end

    // A rejected receive must leave the window untouched.
    `ESP_ASSERT(a_reject_keeps_state,
        step && (item.func == esp_ars_pkg::FN_RECV) &&
        ((res.status == esp_ars_pkg::ST_RANGE) || (res.status == esp_ars_pkg::ST_REPLAY) ||
         (res.status == esp_ars_pkg::ST_AUTH))
        |=> $stable(top_reg) && $stable(window_reg),
        "rejected receive changed the replay state")
    // A data send never hands out sequence zero.
    `ESP_ASSERT(a_send_nonzero,
        step && (item.func == esp_ars_pkg::FN_SEND) && !item.control_frame
        |-> (res.send_seq != 32'd0),
        "send item produced sequence zero")

endmodule

[rtl/esp_antireplay_sequence_engine.sv]
// Top level of the ESP anti-replay sequence engine.
//
// One security association. Items arrive on the s_ stream: s_tuser holds the
// function code, s_tdata the sequence number, verdict and resync values. Each
// item yields exactly one result transfer on the m_ stream: s_tuser-style
// status in m_tuser, outgoing number, rekey flag and window top in m_tdata.
// An accepted item lands in an input register; once the output register is free
// or being emptied, the check, window shift and counter update run in one pass
// and the result is stored in the output register, which drives m_tvalid.
// Throughput is one item per cycle while the receiver keeps m_tready high.
// When the receiver stalls, the output register holds its result, the input
// register keeps one more item and s_tready drops until m_tready returns.
// Reset clears the window top and send counter, fills the window with ones
// and loads the configuration defaults. Registers are written over APB
// (max_advance at 0x0, rekey_threshold at 0x4); the user must write them only
// while the stream is idle, as the block itself does not enforce it.
`include "assert_macros.svh"

module esp_antireplay_sequence_engine (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [103:0] s_tdata,  // seq_number[31:0], auth_ok[32], control_frame[33],
                                   // peer_receive_seq[65:34], peer_send_seq[97:66], zero pad
    input  logic [2:0]  s_tuser,   // func[2:0]
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // send_seq[31:0], rekey_warning[32], window_top[64:33],
                                   // zero pad
    output logic [2:0]  m_tuser,   // status[2:0]
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    esp_ars_pkg::cfg_t    cfg;
    esp_ars_pkg::item_t   in_reg;
    logic                 in_valid_reg;
    esp_ars_pkg::result_t res;
    esp_ars_pkg::result_t out_reg;
    logic                 out_valid_reg;
    logic                 step;
    logic                 in_xfer;

    // An item is processed when the output register is free or being emptied.
    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;
    assign in_xfer  = s_tvalid && s_tready;

    esp_ars_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    esp_ars_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .step  (step),
        .item  (in_reg),
        .res   (res)
    );

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_xfer)
            in_valid_reg <= 1'b1;
        else if (step)
            in_valid_reg <= 1'b0;
    end

    // Input payload capture.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_reg.func             <= s_tuser;
            in_reg.seq_number       <= s_tdata[31:0];
            in_reg.auth_ok          <= s_tdata[32];
            in_reg.control_frame    <= s_tdata[33];
            in_reg.peer_receive_seq <= s_tdata[65:34];
            in_reg.peer_send_seq    <= s_tdata[97:66];
        end
    end

    // Output register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // Result payload capture.
    always_ff @(posedge clk)
    begin
        if (step)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {7'd0, out_reg.window_top, out_reg.rekey_warning, out_reg.send_seq};

    // A full pipeline with a stalled receiver must refuse new input.
    `ESP_ASSERT(a_stall_blocks_input,
        in_valid_reg && out_valid_reg && !m_tready |-> !s_tready,
        "input accepted while both stages are full and stalled")

endmodule

[bench/esp_antireplay_sequence_engine_test.sv]
// Self-checking testbench for the ESP anti-replay sequence engine.
`timescale 1ns / 100ps

module esp_antireplay_sequence_engine_test;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASE_ITEMS  = 150;
    localparam int HOLD_CYCLES  = 200;

    // Prediction of one security association: registers, window and counters.
    class sa_sequence_model;
        logic [15:0]           max_advance;
        logic [31:0]           rekey_threshold;
        logic [31:0]           recv_top;
        esp_ars_pkg::window_t  recv_window;
        logic [31:0]           send_counter;
        esp_ars_pkg::result_t  expected_results[$];
        int                    errors;

        function new();
            max_advance     = esp_ars_pkg::MAX_ADVANCE_RESET;
            rekey_threshold = esp_ars_pkg::REKEY_THRESHOLD_RESET;
            recv_top        = '0;
            recv_window     = '1;
            send_counter    = '0;
            errors          = 0;
        endfunction

        function void set_register(logic reg_idx, logic [31:0] value);
            if (reg_idx == esp_ars_pkg::REG_MAX_ADVANCE)
                max_advance = value[15:0];
            else
                rekey_threshold = value;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Apply one accepted input item and queue the result it must produce.
        function void note_item(esp_ars_pkg::item_t it);
            esp_ars_pkg::result_t r;
            logic [31:0]          fwd_gap;
            logic [31:0]          back;
            r.status        = esp_ars_pkg::ST_DONE;
            r.send_seq      = '0;
            r.rekey_warning = 1'b0;
            case (it.func)
                esp_ars_pkg::FN_RECV:
                begin
                    fwd_gap = it.seq_number - recv_top;
                    back    = 32'd0 - fwd_gap;
                    if (it.seq_number == 32'd0)
                        r.status = it.auth_ok ? esp_ars_pkg::ST_CONTROL : esp_ars_pkg::ST_AUTH;
                    else if (fwd_gap == 32'd0 || fwd_gap[31])
                    begin
                        // At or below the window top: range, replay, then verdict.
                        if (back >= esp_ars_pkg::WINDOW_BITS)
                            r.status = esp_ars_pkg::ST_RANGE;
                        else if (recv_window[back[esp_ars_pkg::WIN_IDX_W-1:0]])
                            r.status = esp_ars_pkg::ST_REPLAY;
                        else if (!it.auth_ok)
                            r.status = esp_ars_pkg::ST_AUTH;
                        else
                        begin
                            recv_window[back[esp_ars_pkg::WIN_IDX_W-1:0]] = 1'b1;
                            r.status = esp_ars_pkg::ST_ACCEPT;
                        end
                    end
                    else if (fwd_gap > {16'd0, max_advance})
                        r.status = esp_ars_pkg::ST_RANGE;
                    else if (!it.auth_ok)
                        r.status = esp_ars_pkg::ST_AUTH;
                    else
                    begin
                        // Forward jump slides the window; a full width clears it.
                        recv_window    = (fwd_gap >= esp_ars_pkg::WINDOW_BITS) ? '0
                                       : recv_window << fwd_gap;
                        recv_window[0] = 1'b1;
                        recv_top       = it.seq_number;
                        r.status       = esp_ars_pkg::ST_ACCEPT;
                    end
                end
                esp_ars_pkg::FN_SEND:
                begin
                    if (!it.control_frame)
                    begin
                        send_counter = send_counter + 32'd1;
                        if (send_counter == 32'd0)
                            send_counter = 32'd1;
                        r.send_seq      = send_counter;
                        r.rekey_warning = (send_counter > rekey_threshold);
                    end
                end
                esp_ars_pkg::FN_RESYNC:
                begin
                    send_counter = it.peer_receive_seq + 32'd1;
                    recv_window  = '1;
                    recv_top     = it.peer_send_seq;
                end
                esp_ars_pkg::FN_RESET_RECV:
                begin
                    recv_top    = '0;
                    recv_window = '1;
                end
                esp_ars_pkg::FN_RESET_SEND:
                    send_counter = '0;
                default:
                    r.status = esp_ars_pkg::ST_DONE;
            endcase
            r.window_top = recv_top;
            expected_results.push_back(r);
        endfunction

        // Compare one result transfer with the oldest expectation.
        function void check_result(esp_ars_pkg::result_t got);
            esp_ars_pkg::result_t want;
            if (expected_results.size() == 0)
            begin
                $error("result with no item outstanding: status %0d window_top %h",
                       got.status, got.window_top);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
            if (got.send_seq !== want.send_seq)
            begin
                $error("send_seq: expected %h, actual %h", want.send_seq, got.send_seq);
                errors++;
            end
            if (got.rekey_warning !== want.rekey_warning)
            begin
                $error("rekey_warning: expected %b, actual %b",
                       want.rekey_warning, got.rekey_warning);
                errors++;
            end
            if (got.window_top !== want.window_top)
            begin
                $error("window_top: expected %h, actual %h", want.window_top, got.window_top);
                errors++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [71:0]  m_tdata;
    logic [2:0]   m_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    sa_sequence_model board;
    int src_idle_pct;
    int sink_idle_pct;
    int hold_cycles;
    int cycle_count;

    esp_antireplay_sequence_engine dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles = hold_cycles - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Result transfers are checked at the clock edge that completes them.
    always @(posedge clk)
    begin : result_monitor
        esp_ars_pkg::result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status        = esp_ars_pkg::status_t'(m_tuser);
            got.send_seq      = m_tdata[31:0];
            got.rekey_warning = m_tdata[32];
            got.window_top    = m_tdata[64:33];
            board.check_result(got);
        end
    end

    // Watchdog against a hung handshake.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    function automatic esp_ars_pkg::item_t make_item(logic [2:0] func, logic [31:0] seq,
                                                     logic auth, logic ctrl,
                                                     logic [31:0] peer_rcv,
                                                     logic [31:0] peer_snd);
        esp_ars_pkg::item_t it;
        it.func             = func;
        it.seq_number       = seq;
        it.auth_ok          = auth;
        it.control_frame    = ctrl;
        it.peer_receive_seq = peer_rcv;
        it.peer_send_seq    = peer_snd;
        return it;
    endfunction

    // Offer one item after random idle cycles and wait for its transfer.
    task automatic send_item(input esp_ars_pkg::item_t it);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, it.peer_send_seq, it.peer_receive_seq, it.control_frame,
                     it.auth_ok, it.seq_number};
        s_tuser  <= it.func;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_item(it);
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register write on the configuration port: setup phase, then access phase.
    task automatic write_register(input logic reg_idx, input logic [31:0] value);
        @(negedge clk);
        s_tvalid <= 1'b0;
        psel     <= 1'b1;
        penable  <= 1'b0;
        pwrite   <= 1'b1;
        paddr    <= {reg_idx, 2'b00};
        pwdata   <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        board.set_register(reg_idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [15:0]         phase_advance [4];
        logic [31:0]         phase_threshold [4];
        int                  phase_src_idle [4];
        int                  phase_sink_idle [4];
        esp_ars_pkg::item_t  it;
        int                  pick;
        int                  lane;
        int                  span;
        int                  u;

        phase_advance   = '{16'd1, 16'd0, 16'd65535, 16'd300};
        phase_threshold = '{32'd0, 32'd40, 32'hFFFF_FFFF, 32'd120};
        phase_src_idle  = '{14, 53, 0, 0};
        phase_sink_idle = '{53, 14, 0, 0};

        board         = new();
        src_idle_pct  = 14;
        sink_idle_pct = 53;
        hold_cycles   = 0;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        m_tready      = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part under the reset configuration.
        // Control frame received, with and without a passing verdict.
        send_item(make_item(esp_ars_pkg::FN_RECV, 32'd0, 1'b1, 1'b0, 32'd0, 32'd0));
        send_item(make_item(esp_ars_pkg::FN_RECV, 32'd0, 1'b0, 1'b1, '1, '1));
        // Just below top zero: the window starts full, so this is a replay.
        send_item(make_item(esp_ars_pkg::FN_RECV, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'd0, 32'd0));
        send_item(make_item(esp_ars_pkg::FN_RECV, 32'd1, 1'b0, 1'b0, 32'd0, 32'd0));
        send_item(make_item(esp_ars_pkg::FN_RECV, 32'd1, 1'b1, 1'b0, 32'd0, 32'd0));
        send_item(make_item(esp_ars_pkg::FN_RECV, 32'd1, 1'b1, 1'b0, 32'd0, 32'd0));
        // A jump of the full window width clears it; exactly that distance back is out.
        send_item(make_item(esp_ars_pkg::FN_RECV, 32'd65, 1'b1, 1'b0, 32'd0, 32'd0));
        send_item(make_item(esp_ars_pkg::FN_RECV, 32'd1, 1'b1, 1'b0, 32'd0, 32'd0));
        send_item(make_item(esp_ars_pkg::FN_RECV, 32'd2, 1'b0, 1'b0, 32'd0, 32'd0));
        send_item(make_item(esp_ars_pkg::FN_RECV, 32'd2, 1'b1, 1'b0, 32'd0, 32'd0));
        // Largest allowed forward jump, then one past it.
        send_item(make_item(esp_ars_pkg::FN_RECV, 32'd16449, 1'b1, 1'b0, 32'd0, 32'd0));
        send_item(make_item(esp_ars_pkg::FN_RECV, 32'd32834, 1'b1, 1'b0, 32'd0, 32'd0));
        // Send side: control frame, normal, then counter wrap after a resync.
        send_item(make_item(esp_ars_pkg::FN_SEND, 32'd0, 1'b0, 1'b1, 32'd0, 32'd0));
        send_item(make_item(esp_ars_pkg::FN_SEND, '1, 1'b1, 1'b0, '1, '1));
        send_item(make_item(esp_ars_pkg::FN_RESYNC, 32'd0, 1'b0, 1'b0, 32'hFFFF_FFFE,
                            32'hFFFF_FFF0));
        send_item(make_item(esp_ars_pkg::FN_SEND, 32'd0, 1'b0, 1'b0, 32'd0, 32'd0));
        send_item(make_item(esp_ars_pkg::FN_SEND, 32'd0, 1'b0, 1'b0, 32'd0, 32'd0));
        // Forward across the 32-bit wrap of the receive top.
        send_item(make_item(esp_ars_pkg::FN_RECV, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'd0, 32'd0));
        send_item(make_item(esp_ars_pkg::FN_RECV, 32'h0000_0010, 1'b1, 1'b0, 32'd0, 32'd0));
        send_item(make_item(esp_ars_pkg::FN_RESYNC, '1, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'd0));
        send_item(make_item(esp_ars_pkg::FN_SEND, 32'd0, 1'b0, 1'b0, 32'd0, 32'd0));
        send_item(make_item(esp_ars_pkg::FN_RESET_RECV, '1, 1'b1, 1'b1, '1, '1));
        send_item(make_item(esp_ars_pkg::FN_RESET_SEND, 32'd0, 1'b0, 1'b0, 32'd0, 32'd0));
        // Unused function codes change nothing.
        for (u = esp_ars_pkg::FN_RESET_SEND + 1; u <= 7; u++)
            send_item(make_item(3'(u), $urandom, 1'b1, 1'b1, $urandom, $urandom));

        // Random phases, each with its own register setting and idle pattern.
        for (int phase = 0; phase < 4; phase++)
        begin
            wait_drained();
            write_register(esp_ars_pkg::REG_MAX_ADVANCE, {16'd0, phase_advance[phase]});
            write_register(esp_ars_pkg::REG_REKEY_THRESHOLD, phase_threshold[phase]);
            src_idle_pct  = phase_src_idle[phase];
            sink_idle_pct = phase_sink_idle[phase];
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // The sender stops until every outstanding result is back.
                if (n == 75)
                    wait_drained();
                // The receiver holds off while the sender keeps offering.
                if (phase == 2 && n == 40)
                    hold_cycles = HOLD_CYCLES;

                it.func             = esp_ars_pkg::FN_RECV;
                it.seq_number       = $urandom;
                it.auth_ok          = ($urandom_range(9) != 0);
                it.control_frame    = ($urandom_range(6) == 0);
                it.peer_receive_seq = $urandom;
                it.peer_send_seq    = $urandom;
                pick = $urandom_range(99);
                if (pick < 55)
                begin
                    // Receive numbers mostly around the current window.
                    lane = $urandom_range(9);
                    span = int'(board.max_advance) + 2;
                    if (span > 100 && $urandom_range(1) == 0)
                        span = 100;
                    if (lane < 4)
                        it.seq_number = board.recv_top - 32'($urandom_range(70));
                    else if (lane < 8)
                        it.seq_number = board.recv_top + 32'($urandom_range(span, 1));
                    else if (lane == 8)
                        it.seq_number = 32'd0;
                end
                else if (pick < 80)
                    it.func = esp_ars_pkg::FN_SEND;
                else if (pick < 85)
                begin
                    it.func = esp_ars_pkg::FN_RESYNC;
                    if ($urandom_range(3) == 0)
                        it.peer_receive_seq = 32'hFFFF_FFFF - 32'($urandom_range(3));
                end
                else if (pick < 89)
                    it.func = esp_ars_pkg::FN_RESET_RECV;
                else if (pick < 93)
                    it.func = esp_ars_pkg::FN_RESET_SEND;
                else
                    it.func = 3'($urandom_range(7, esp_ars_pkg::FN_RESET_SEND + 1));
                send_item(it);
            end
        end

        // Let the last results drain, then report.
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait_drained();
        if (board.errors == 0 && board.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/esp_ars_pkg.sv
rtl/esp_ars_apb_regs.sv
rtl/esp_ars_engine.sv
rtl/esp_antireplay_sequence_engine.sv
bench/esp_antireplay_sequence_engine_test.sv
